/* src/u8u16_pkg.sv */
package u8u16_pkg;

    localparam int unsigned DATA_W  = 8;
    localparam int unsigned CP_W    = 21;
    localparam int unsigned UNIT_W  = 16;
    localparam int unsigned TDATA_W = 64;

    localparam logic [CP_W-1:0]   CP_MAX      = 21'h10FFFF;
    localparam logic [CP_W-1:0]   SURR_LO     = 21'h00D800;
    localparam logic [CP_W-1:0]   SURR_HI     = 21'h00DFFF;
    localparam logic [CP_W-1:0]   SUPP_BASE   = 21'h010000;
    localparam logic [CP_W-1:0]   MIN_2BYTE   = 21'h000080;
    localparam logic [CP_W-1:0]   MIN_3BYTE   = 21'h000800;
    localparam logic [UNIT_W-1:0] HIGH_SURR   = 16'hD800;
    localparam logic [UNIT_W-1:0] LOW_SURR    = 16'hDC00;

    typedef enum logic [1:0] {
        KIND_POINT = 2'd0,
        KIND_ERROR = 2'd1,
        KIND_CLOSE = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_LEAD      = 3'd0,
        ERR_CONT      = 3'd1,
        ERR_TRUNC     = 3'd2,
        ERR_OVERLONG  = 3'd3,
        ERR_SURROGATE = 3'd4,
        ERR_RANGE     = 3'd5
    } t_err;

    typedef struct packed {
        logic [1:0]      remaining;
        logic [1:0]      seq_len;
        logic [CP_W-1:0] acc;
        logic            err_latched;
    } t_seq_state;

    typedef struct packed {
        t_kind             kind;
        logic [CP_W-1:0]   code_point;
        logic [UNIT_W-1:0] first_unit;
        logic [UNIT_W-1:0] second_unit;
        logic              unit_pair;
        t_err              error_code;
        logic              last;
    } t_result;

endpackage

/* src/u8u16_dec.sv */
module u8u16_dec
    import u8u16_pkg::*;
(
    input  logic [DATA_W-1:0] i_byte,
    input  logic              i_end,
    input  t_seq_state        i_state,
    output t_seq_state        o_state,
    output logic              o_produce,
    output t_result           o_result
);

    localparam t_seq_state IDLE_STATE = '{remaining: 2'd0, seq_len: 2'd0,
                                         acc: '0, err_latched: 1'b0};

    function automatic t_result make_point(input logic [CP_W-1:0] cp, input logic last);
        t_result         r;
        logic [CP_W-1:0] adj;
        r            = '0;
        adj          = cp - SUPP_BASE;
        r.kind       = KIND_POINT;
        r.code_point = cp;
        r.last       = last;
        if (cp < SUPP_BASE) begin
            r.first_unit = cp[UNIT_W-1:0];
        end else begin
            r.first_unit  = HIGH_SURR + {6'd0, adj[19:10]};
            r.second_unit = LOW_SURR + {6'd0, adj[9:0]};
            r.unit_pair   = 1'b1;
        end
        return r;
    endfunction

    function automatic t_result make_error(input t_err code, input logic last);
        t_result r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        r.last       = last;
        return r;
    endfunction

    logic [CP_W-1:0] acc_next;
    logic [1:0]      rem_next;
    logic            cont_ok;
    logic            overlong;

    assign acc_next = {i_state.acc[14:0], i_byte[5:0]};
    assign rem_next = i_state.remaining - 2'd1;
    assign cont_ok  = (i_byte[7:6] == 2'b10);
    assign overlong = (i_state.seq_len == 2'd1 && acc_next < MIN_2BYTE) ||
                      (i_state.seq_len == 2'd2 && acc_next < MIN_3BYTE) ||
                      (i_state.seq_len == 2'd3 && acc_next < SUPP_BASE);

    always_comb begin
        o_state   = i_state;
        o_produce = 1'b0;
        o_result  = '0;
        if (i_state.err_latched) begin
            if (i_end) begin
                o_produce     = 1'b1;
                o_result.kind = KIND_CLOSE;
                o_result.last = 1'b1;
                o_state       = IDLE_STATE;
            end
        end else if (i_state.remaining == 2'd0) begin
            priority if (i_byte[7] == 1'b0) begin
                o_produce = 1'b1;
                o_result  = make_point({13'd0, i_byte}, i_end);
                o_state   = IDLE_STATE;
            end else if (i_byte[7:5] == 3'b110 || i_byte[7:4] == 4'b1110 ||
                         i_byte[7:3] == 5'b11110) begin
                if (i_end) begin
                    // multi-byte lead on the closing byte
                    o_produce = 1'b1;
                    o_result  = make_error(ERR_TRUNC, 1'b1);
                    o_state   = IDLE_STATE;
                end else if (i_byte[5] == 1'b0) begin
                    o_state.seq_len   = 2'd1;
                    o_state.remaining = 2'd1;
                    o_state.acc       = {16'd0, i_byte[4:0]};
                end else if (i_byte[4] == 1'b0) begin
                    o_state.seq_len   = 2'd2;
                    o_state.remaining = 2'd2;
                    o_state.acc       = {17'd0, i_byte[3:0]};
                end else begin
                    o_state.seq_len   = 2'd3;
                    o_state.remaining = 2'd3;
                    o_state.acc       = {18'd0, i_byte[2:0]};
                end
            end else begin
                o_produce             = 1'b1;
                o_result              = make_error(ERR_LEAD, i_end);
                o_state               = IDLE_STATE;
                o_state.err_latched   = ~i_end;
            end
        end else if (i_end && i_state.remaining > 2'd1) begin
            o_produce = 1'b1;
            o_result  = make_error(ERR_TRUNC, 1'b1);
            o_state   = IDLE_STATE;
        end else if (!cont_ok) begin
            o_produce           = 1'b1;
            o_result            = make_error(ERR_CONT, i_end);
            o_state             = IDLE_STATE;
            o_state.err_latched = ~i_end;
        end else if (rem_next != 2'd0) begin
            o_state.acc       = acc_next;
            o_state.remaining = rem_next;
        end else begin
            o_produce           = 1'b1;
            o_state             = IDLE_STATE;
            priority if (overlong) begin
                o_result            = make_error(ERR_OVERLONG, i_end);
                o_state.err_latched = ~i_end;
            end else if (acc_next >= SURR_LO && acc_next <= SURR_HI) begin
                o_result            = make_error(ERR_SURROGATE, i_end);
                o_state.err_latched = ~i_end;
            end else if (acc_next > CP_MAX) begin
                o_result            = make_error(ERR_RANGE, i_end);
                o_state.err_latched = ~i_end;
            end else begin
                o_result = make_point(acc_next, i_end);
            end
        end
    end

endmodule

/* src/utf8_to_utf16_strict_decoder_top.sv */
// Channel  | Dir | Handshake              | Payload
// s_axis   | in  | tvalid/tready          | tdata[7:0] data_byte, tlast string_end
// m_axis   | out | tvalid/tready          | tdata code_point..error_code, tuser result_kind,
//          |     |                        | tlast last_of_string
//
// One byte per cycle while the skid entry is empty; each result is registered.
// Sequence state updates in the same cycle the byte is taken; decode is one level deep.
// Output register plus one skid entry: input stalls only while the skid entry is full.
// i_rst_n is synchronous, active low, and clears sequence state and both result slots.
module utf8_to_utf16_strict_decoder_top
    import u8u16_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [DATA_W-1:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic               i_s_axis_tlast,   // string_end
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [TDATA_W-1:0] o_m_axis_tdata,   // [20:0] code_point, [36:21] first_unit,
                                                 // [52:37] second_unit, [53] unit_pair,
                                                 // [56:54] error_code, [63:57] zero
    output logic [1:0]         o_m_axis_tuser,   // [1:0] result_kind
    output logic               o_m_axis_tlast    // last_of_string
);

    t_seq_state r_seq;
    t_seq_state n_seq;
    t_result    n_res;
    logic       n_produce;
    t_result    r_out;
    logic       r_out_valid;
    t_result    r_skd;
    logic       r_skd_valid;
    logic       in_req;
    logic       out_pop;

    assign o_s_axis_tready = ~r_skd_valid;
    assign in_req          = i_s_axis_tvalid & ~r_skd_valid;
    assign out_pop         = r_out_valid & i_m_axis_tready;

    u8u16_dec u_dec (
        .i_byte    (i_s_axis_tdata),
        .i_end     (i_s_axis_tlast),
        .i_state   (r_seq),
        .o_state   (n_seq),
        .o_produce (n_produce),
        .o_result  (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= '0;
        end else if (in_req) begin
            r_seq <= n_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (out_pop || !r_out_valid) begin
            if (r_skd_valid) begin
                r_out_valid <= 1'b1;
                r_skd_valid <= 1'b0;
            end else begin
                r_out_valid <= in_req & n_produce;
            end
        end else if (in_req && n_produce) begin
            r_skd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_pop || !r_out_valid) begin
            if (r_skd_valid) begin
                r_out <= r_skd;
            end else if (in_req && n_produce) begin
                r_out <= n_res;
            end
        end else if (in_req && n_produce) begin
            r_skd <= n_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out.last;
    assign o_m_axis_tdata  = {7'd0, r_out.error_code, r_out.unit_pair, r_out.second_unit,
                              r_out.first_unit, r_out.code_point};

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |-> r_out_valid)
        else $error("skid entry holds a result while output slot is empty");

    a_close_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_CLOSE) |-> r_out.last)
        else $error("closing result without end-of-string mark");

    a_error_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_ERROR) |->
        (r_out.code_point == '0 && r_out.unit_pair == 1'b0))
        else $error("error result carries a code point");

    a_pair_is_supp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.unit_pair) |->
        (r_out.code_point >= SUPP_BASE && r_out.code_point <= CP_MAX))
        else $error("surrogate pair for a BMP or out-of-range value");

endmodule

/* tb/sv/u8u16_result_checker.sv */
`timescale 1ns / 1ps

module u8u16_result_checker
    import u8u16_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  logic               i_s_tready,
    input  logic [DATA_W-1:0]  i_s_tdata,    // [7:0] data_byte
    input  logic               i_s_tlast,    // string_end
    input  logic               i_m_tvalid,
    input  logic               i_m_tready,
    input  logic [TDATA_W-1:0] i_m_tdata,    // [20:0] code_point, [36:21] first_unit,
                                             // [52:37] second_unit, [53] unit_pair,
                                             // [56:54] error_code, [63:57] zero
    input  logic [1:0]         i_m_tuser,    // [1:0] result_kind
    input  logic               i_m_tlast,    // last_of_string
    output int                 o_fail_count,
    output int                 o_pending
);

    // decoder shadow state
    logic [1:0]      rem_cnt;
    logic [1:0]      seq_len;
    logic [CP_W-1:0] acc;
    logic            drop_mode;

    t_result         decoded_q[$];
    t_result         want;
    int              mismatch_total;

    task automatic clear_seq();
        rem_cnt = '0;
        seq_len = '0;
        acc     = '0;
    endtask

    task automatic queue_result(input t_result r);
        decoded_q.insert(decoded_q.size(), r);
    endtask

    task automatic push_point(input logic [CP_W-1:0] cp, input logic fin);
        t_result         r;
        logic [CP_W-1:0] adj;
        r            = '0;
        r.kind       = KIND_POINT;
        r.error_code = ERR_LEAD;
        r.code_point = cp;
        r.last       = fin;
        if (cp < SUPP_BASE) begin
            r.first_unit = cp[UNIT_W-1:0];
        end else begin
            adj           = cp - SUPP_BASE;
            r.first_unit  = HIGH_SURR + UNIT_W'(adj[19:10]);
            r.second_unit = LOW_SURR + UNIT_W'(adj[9:0]);
            r.unit_pair   = 1'b1;
        end
        queue_result(r);
        clear_seq();
    endtask

    task automatic push_error(input t_err code, input logic fin);
        t_result r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        r.last       = fin;
        queue_result(r);
        clear_seq();
        drop_mode = !fin;
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic fin);
        t_result r;
        if (drop_mode) begin
            if (fin) begin
                r            = '0;
                r.kind       = KIND_CLOSE;
                r.error_code = ERR_LEAD;
                r.last       = 1'b1;
                queue_result(r);
                drop_mode = 1'b0;
                clear_seq();
            end
        end else if (rem_cnt == 2'd0) begin
            if (!b[7]) begin
                push_point(CP_W'(b[6:0]), fin);
            end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
                if (b[7:5] == 3'b110) begin
                    seq_len = 2'd1;
                    acc     = CP_W'(b[4:0]);
                end else if (b[7:4] == 4'b1110) begin
                    seq_len = 2'd2;
                    acc     = CP_W'(b[3:0]);
                end else begin
                    seq_len = 2'd3;
                    acc     = CP_W'(b[2:0]);
                end
                rem_cnt = seq_len;
                if (fin) push_error(ERR_TRUNC, fin);
            end else begin
                push_error(ERR_LEAD, fin);
            end
        end else if (fin && rem_cnt > 2'd1) begin
            // end byte while more than one continuation is still owed
            push_error(ERR_TRUNC, fin);
        end else if (b[7:6] != 2'b10) begin
            push_error(ERR_CONT, fin);
        end else begin
            acc     = {acc[CP_W-7:0], b[5:0]};
            rem_cnt = rem_cnt - 2'd1;
            if (rem_cnt == 2'd0) begin
                if ((seq_len == 2'd1 && acc < MIN_2BYTE) ||
                    (seq_len == 2'd2 && acc < MIN_3BYTE) ||
                    (seq_len == 2'd3 && acc < SUPP_BASE))
                    push_error(ERR_OVERLONG, fin);
                else if (acc >= SURR_LO && acc <= SURR_HI)
                    push_error(ERR_SURROGATE, fin);
                else if (acc > CP_MAX)
                    push_error(ERR_RANGE, fin);
                else
                    push_point(acc, fin);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_seq();
            drop_mode = 1'b0;
            decoded_q.delete();
            mismatch_total = 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                predict_byte(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                if (decoded_q.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= 10)
                        $display("unexpected result: kind=%0d tdata=%h last=%b",
                                 i_m_tuser, i_m_tdata, i_m_tlast);
                end else begin
                    want = decoded_q.pop_front();
                    if (i_m_tuser != want.kind || i_m_tdata[20:0] != want.code_point ||
                        i_m_tdata[36:21] != want.first_unit ||
                        i_m_tdata[52:37] != want.second_unit ||
                        i_m_tdata[53] != want.unit_pair ||
                        i_m_tdata[56:54] != want.error_code ||
                        i_m_tdata[63:57] != '0 || i_m_tlast != want.last) begin
                        mismatch_total++;
                        if (mismatch_total <= 10)
                            $display({"mismatch: exp kind=%0d cp=%h u1=%h u2=%h pair=%b ",
                                      "err=%0d last=%b | got kind=%0d cp=%h u1=%h u2=%h ",
                                      "pair=%b err=%0d pad=%h last=%b"},
                                     want.kind, want.code_point, want.first_unit,
                                     want.second_unit, want.unit_pair, want.error_code,
                                     want.last, i_m_tuser, i_m_tdata[20:0],
                                     i_m_tdata[36:21], i_m_tdata[52:37], i_m_tdata[53],
                                     i_m_tdata[56:54], i_m_tdata[63:57], i_m_tlast);
                    end
                end
            end
        end
        o_fail_count <= mismatch_total;
        o_pending    <= decoded_q.size();
    end

endmodule

/* tb/sv/utf8_to_utf16_strict_decoder_top_tb.sv */
`timescale 1ns / 1ps

module utf8_to_utf16_strict_decoder_top_tb;
    import u8u16_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int BYTE_TARGET = 1850;
    localparam int IDLE_PCT    = 24;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [DATA_W-1:0]  s_tdata = '0;
    logic               s_tlast = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;
    logic               m_tlast;

    int                 fail_count;
    int                 pending;
    int                 stall_cycles = 0;
    int                 sent_count = 0;
    logic               quiet = 1'b0;
    logic [7:0]         str_q[$];

    utf8_to_utf16_strict_decoder_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    u8u16_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("utf8_to_utf16_strict_decoder_top test failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (!quiet) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent_count++;
        quiet <= (sent_count >= 700 && sent_count < 1000);
    endtask

    task automatic send_string();
        for (int i = 0; i < str_q.size(); i++)
            send_byte(str_q[i], i == str_q.size() - 1);
    endtask

    task automatic add_byte(input logic [7:0] b);
        str_q.insert(str_q.size(), b);
    endtask

    task automatic add_utf8(input logic [20:0] cp, input int n);
        unique case (n)
            1: add_byte({1'b0, cp[6:0]});
            2: begin
                add_byte({3'b110, cp[10:6]});
                add_byte({2'b10, cp[5:0]});
            end
            3: begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
            default: begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
        endcase
    endtask

    // mostly well-formed scalars, with a tail of broken encodings
    task automatic add_random_point();
        int          r;
        int          n;
        int          cut;
        logic [20:0] cp;
        r = $urandom_range(99);
        n = $urandom_range(1, 4);
        if (r < 86) begin
            unique case (n)
                1: cp = 21'($urandom_range(0, 'h7F));
                2: cp = 21'($urandom_range('h80, 'h7FF));
                3: begin
                    cp = 21'($urandom_range('h800, 'hFFFF));
                    if (cp >= 'hD800 && cp <= 'hDFFF) cp = cp ^ 21'h2000;
                end
                default: cp = 21'($urandom_range('h10000, 'h10FFFF));
            endcase
            add_utf8(cp, n);
        end else if (r < 89) begin
            n = $urandom_range(2, 4);
            if (n == 2)      cp = 21'($urandom_range(0, 'h7F));
            else if (n == 3) cp = 21'($urandom_range(0, 'h7FF));
            else             cp = 21'($urandom_range(0, 'hFFFF));
            add_utf8(cp, n);
        end else if (r < 91) begin
            add_utf8(21'($urandom_range('hD800, 'hDFFF)), 3);
        end else if (r < 93) begin
            add_utf8(21'($urandom_range('h110000, 'h1FFFFF)), 4);
        end else if (r < 95) begin
            if ($urandom_range(1))
                add_byte(8'($urandom_range('h80, 'hBF)));
            else
                add_byte(8'($urandom_range('hF8, 'hFF)));
        end else begin
            n   = $urandom_range(2, 4);
            cp  = 21'($urandom_range('h80, 'h10FFFF));
            add_utf8(cp, n);
            cut = $urandom_range(1, n - 1);
            if (r < 98)
                repeat (cut) void'(str_q.pop_back());
            else
                str_q[str_q.size() - cut] = 8'($urandom_range(0, 255));
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ascii extremes, smallest two-byte, largest scalar as a pair
        str_q = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_string();
        // overlong caught on the end byte
        str_q = '{8'hC0, 8'h80};
        send_string();
        // surrogate, then dropped bytes and a closing result
        str_q = '{8'hED, 8'hA0, 8'h80, 8'h41, 8'hFF};
        send_string();
        str_q = '{8'hF4, 8'h90, 8'h80, 8'h80};
        send_string();
        str_q = '{8'h80};
        send_string();
        // bad continuation mid-string
        str_q = '{8'hE0, 8'h41, 8'h00};
        send_string();
        // end byte while two continuations are owed
        str_q = '{8'hE0, 8'hA0};
        send_string();
        // multi-byte lead as the end byte
        str_q = '{8'hF0};
        send_string();

        while (sent_count < BYTE_TARGET) begin
            str_q.delete();
            repeat ($urandom_range(1, 6)) add_random_point();
            send_string();
        end
        s_tvalid <= 1'b0;

        // let the checker count the last request before polling
        @(posedge i_clk);
        wait (pending == 0);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("utf8_to_utf16_strict_decoder_top test passed");
        else
            $display("utf8_to_utf16_strict_decoder_top test failed");
        $finish;
    end

endmodule
